FILE: design/slt_pkg.sv
// Shared types and operation codes for the sorted list table.
package slt_pkg;

    // Request codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Depth of the request queue between front and engine
    localparam int QUEUE_DEPTH = 2;

    // Request item as seen on the input port
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } t_in;

    // Result item as seen on the output port
    typedef struct packed {
        logic       success;
        logic [5:0] position;
        logic [6:0] entry_count;
    } t_out;

endpackage

FILE: design/slt_front.sv
// Request front end: accepts items, decodes the operation, forms the
// ordered key and queues the request for the engine.
module slt_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  slt_pkg::t_in           i_in_data,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_ready,
    output slt_pkg::t_op           o_cmd_op,
    output logic [VALUE_WIDTH-1:0] o_cmd_key
);

    localparam int PW = $clog2(slt_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(slt_pkg::QUEUE_DEPTH + 1);

    slt_pkg::t_op           r_q_op  [slt_pkg::QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_q_key [slt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]          r_wr_ptr;
    logic [PW-1:0]          r_rd_ptr;
    logic [NW-1:0]          r_fill;

    logic [VALUE_WIDTH-1:0] ext_value;
    logic [VALUE_WIDTH-1:0] key;
    logic                   push;
    logic                   pop;

    // Sign-extend or truncate, then flip the sign bit so that an unsigned
    // compare orders keys as signed values
    always_comb begin
        ext_value = VALUE_WIDTH'(i_in_data.value);
        key       = {~ext_value[VALUE_WIDTH-1], ext_value[VALUE_WIDTH-2:0]};
    end

    assign o_in_ready  = (r_fill != NW'(slt_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd_op    = r_q_op[r_rd_ptr];
    assign o_cmd_key   = r_q_key[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wr_ptr]  <= slt_pkg::t_op'(i_in_data.operation);
            r_q_key[r_wr_ptr] <= key;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(slt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(slt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

FILE: design/slt_engine.sv
// Table engine: entry memory, linear search and shift sequencer, and the
// result output register.
module slt_engine #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  slt_pkg::t_op           i_cmd_op,
    input  logic [VALUE_WIDTH-1:0] i_cmd_key,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output slt_pkg::t_out          o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_CLOSE,
        ST_DONE
    } t_state;

    // Entry memory, one write and one registered read per cycle
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    t_state                 r_state;
    slt_pkg::t_op           r_op;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_j;
    logic                   r_ok;
    logic [5:0]             r_pos;
    logic                   r_out_valid;
    slt_pkg::t_out          r_out;

    logic                   in_range;
    logic                   hit;
    logic                   match;
    logic [CW:0]            j_next;
    logic                   more_close;
    logic                   load_out;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Result register takes a new item when empty or being drained
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Search and shift conditions
    always_comb begin
        in_range   = (r_idx < r_count);
        hit        = !in_range || (r_rd_data >= r_key);
        match      = in_range && (r_rd_data == r_key);
        j_next     = (CW+1)'(r_j) + (CW+1)'(1);
        more_close = (j_next < (CW+1)'(r_count));
    end

    // Memory addressing per state
    always_comb begin
        rd_addr = AW'(r_idx + 1'b1);
        mem_we  = 1'b0;
        wr_addr = AW'(r_j);
        wr_data = r_rd_data;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
            end
            ST_SEARCH: begin
                if (hit && r_op == slt_pkg::OP_INSERT) begin
                    rd_addr = AW'(r_count - 1'b1);
                end
            end
            ST_SHIFT: begin
                mem_we = 1'b1;
                if (r_j == r_idx) begin
                    wr_addr = AW'(r_idx);
                    wr_data = r_key;
                end else begin
                    rd_addr = AW'(r_j - CW'(2));
                end
            end
            ST_CLOSE: begin
                rd_addr = AW'(r_j + CW'(2));
                mem_we  = more_close;
            end
            ST_DONE: begin
                rd_addr = '0;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op  <= i_cmd_op;
                        r_key <= i_cmd_key;
                        r_idx <= '0;
                        r_ok  <= 1'b0;
                        r_pos <= '0;
                        if (i_cmd_op == slt_pkg::OP_CLEAR) begin
                            r_count <= '0;
                            r_ok    <= 1'b1;
                            r_state <= ST_DONE;
                        end else if (i_cmd_op == slt_pkg::OP_INSERT &&
                                     r_count == CW'(CAPACITY)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (hit) begin
                        case (r_op)
                            slt_pkg::OP_INSERT: begin
                                r_j     <= r_count;
                                r_state <= ST_SHIFT;
                            end
                            slt_pkg::OP_DELETE: begin
                                r_j     <= r_idx;
                                r_state <= match ? ST_CLOSE : ST_DONE;
                            end
                            default: begin
                                r_ok    <= match;
                                r_pos   <= match ? 6'(r_idx) : '0;
                                r_state <= ST_DONE;
                            end
                        endcase
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SHIFT: begin
                    // move entries up by one from the tail, then drop the key in
                    if (r_j == r_idx) begin
                        r_count <= r_count + 1'b1;
                        r_ok    <= 1'b1;
                        r_pos   <= 6'(r_idx);
                        r_state <= ST_DONE;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                ST_CLOSE: begin
                    // move entries down by one over the deleted slot
                    if (more_close) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_ok    <= 1'b1;
                        r_pos   <= 6'(r_idx);
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_out.success     <= r_ok;
                        r_out.position    <= r_pos;
                        r_out.entry_count <= 7'(r_count);
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/sorted_list_table.sv
// Sorted list table: ordered storage of signed values with insert, find,
// delete and clear requests.
//
// Requests enter on i_in_valid / o_in_ready with i_in_data (operation,
// value); every request returns exactly one result item on o_out_valid /
// i_out_ready with o_out_data (success, position, entry_count).
// A two-entry request queue takes items while the engine is busy, so the
// sender sees back pressure only when two requests are already waiting.
// The engine handles one request at a time. It walks the entry memory one
// entry per cycle to find the first entry not below the key, then an insert
// shifts the tail up and a delete shifts it down, one entry per cycle through
// the separate read and write ports of the memory. A clear, and an insert
// into a full table, skip the walk and go straight to the result.
// The result sits in an output register; while the receiver stalls the
// engine holds its next result and the queue keeps filling.
// Reset empties the table and the queue at once; no clearing pass is run,
// entries are only read after they are written.
module sorted_list_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  slt_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output slt_pkg::t_out  o_out_data
);

    logic                   cmd_valid;
    logic                   cmd_ready;
    slt_pkg::t_op           cmd_op;
    logic [VALUE_WIDTH-1:0] cmd_key;

    // Accept and decode requests
    slt_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd_op    (cmd_op),
        .o_cmd_key   (cmd_key)
    );

    // Carry out requests on the table
    slt_engine #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd_op    (cmd_op),
        .i_cmd_key   (cmd_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: bench/slt_checker.sv
// Result checker for the sorted list table: predicts each request's result and compares.
module slt_checker #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  slt_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  slt_pkg::t_out  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // A request together with the result it should produce
    typedef struct {
        slt_pkg::t_in  req;
        slt_pkg::t_out res;
    } t_awaited;

    // Shadow copy of the table contents, kept in ascending order
    logic signed [31:0] shadow_vals [CAPACITY];
    int                 shadow_count;
    t_awaited           awaited_results [$];
    t_awaited           oldest;

    // Apply one request to the shadow table and return its result item
    function automatic slt_pkg::t_out apply_request(slt_pkg::t_in req);
        slt_pkg::t_out      r;
        logic signed [31:0] v;
        int                 lb;
        slt_pkg::t_op       op;
        r  = '0;
        v  = req.value;
        op = slt_pkg::t_op'(req.operation);
        // first stored entry not below the operand
        lb = 0;
        while (lb < shadow_count && shadow_vals[lb] < v)
            lb++;
        case (op)
            slt_pkg::OP_CLEAR: begin
                shadow_count = 0;
                r.success = 1'b1;
            end
            slt_pkg::OP_INSERT: begin
                // a full table rejects the insert and keeps its contents
                if (shadow_count < CAPACITY) begin
                    for (int j = shadow_count; j > lb; j--)
                        shadow_vals[j] = shadow_vals[j-1];
                    shadow_vals[lb] = v;
                    shadow_count++;
                    r.success  = 1'b1;
                    r.position = 6'(lb);
                end
            end
            default: begin
                // find and delete act on the first equal entry only
                if (lb < shadow_count && shadow_vals[lb] == v) begin
                    r.success  = 1'b1;
                    r.position = 6'(lb);
                    if (op == slt_pkg::OP_DELETE) begin
                        for (int j = lb; j + 1 < shadow_count; j++)
                            shadow_vals[j] = shadow_vals[j+1];
                        shadow_count--;
                    end
                end
            end
        endcase
        r.entry_count = 7'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, slt_pkg::t_in req, slt_pkg::t_out want);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display({"%0t checker: %s (op %0d value %0d): ",
                      "expected ok %0b pos %0d count %0d, got ok %0b pos %0d count %0d"},
                     $time, what, req.operation, req.value,
                     want.success, want.position, want.entry_count,
                     i_out_data.success, i_out_data.position, i_out_data.entry_count);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        shadow_count = 0;
    end

    // Results are compared before new requests are taken in, so a result
    // can never be matched against a request accepted at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request pending", '0, '0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_out_data.success !== oldest.res.success
                        || i_out_data.position !== oldest.res.position
                        || i_out_data.entry_count !== oldest.res.entry_count)
                        report_mismatch("wrong result", oldest.req, oldest.res);
                end
            end
            if (i_in_valid && i_in_ready) begin
                oldest.req = i_in_data;
                oldest.res = apply_request(i_in_data);
                awaited_results.push_back(oldest);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: bench/tb.sv
// Testbench top for the sorted list table: clock, reset, request stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 950;
    localparam int HOLD_OFF_AT    = 300;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 16;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    slt_pkg::t_in   in_data;
    logic           out_valid;
    logic           out_ready;
    slt_pkg::t_out  out_data;
    int             fail_count;
    int             pending;

    int    sent_items;
    int    burst_left;
    int    idle_cycles;

    // Values that recur often, so finds and deletes hit stored entries
    logic signed [31:0] value_pool [POOL_SIZE];

    sorted_list_table DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    slt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one request; bursts of back-to-back items with random gaps between
    task automatic send(slt_pkg::t_op op, logic signed [31:0] v);
        slt_pkg::t_in req;
        int           gap;
        req.operation = op;
        req.value     = v;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // Operation mix: 0 fills the table, 1 drains it, 2 mixes both
    function automatic slt_pkg::t_op pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (roll < 1) return slt_pkg::OP_CLEAR;
                if (roll < 81) return slt_pkg::OP_INSERT;
                if (roll < 91) return slt_pkg::OP_FIND;
                return slt_pkg::OP_DELETE;
            end
            1: begin
                if (roll < 1) return slt_pkg::OP_CLEAR;
                if (roll < 15) return slt_pkg::OP_INSERT;
                if (roll < 40) return slt_pkg::OP_FIND;
                return slt_pkg::OP_DELETE;
            end
            default: begin
                if (roll < 2) return slt_pkg::OP_CLEAR;
                if (roll < 40) return slt_pkg::OP_INSERT;
                if (roll < 70) return slt_pkg::OP_FIND;
                return slt_pkg::OP_DELETE;
            end
        endcase
    endfunction

    // Stimulus
    initial begin : stimulus
        int mode;
        int len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        sent_items = 0;
        burst_left = 0;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = (i < 10) ? $signed($urandom_range(0, 40)) - 20 : $urandom();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, extremes, duplicates, hits and misses
        send(slt_pkg::OP_CLEAR, 0);
        send(slt_pkg::OP_FIND, 5);
        send(slt_pkg::OP_DELETE, 5);
        send(slt_pkg::OP_INSERT, 0);
        send(slt_pkg::OP_INSERT, VAL_MAX);
        send(slt_pkg::OP_INSERT, VAL_MIN);
        send(slt_pkg::OP_INSERT, -1);
        send(slt_pkg::OP_INSERT, 1);
        send(slt_pkg::OP_INSERT, 0);
        send(slt_pkg::OP_FIND, 0);
        send(slt_pkg::OP_FIND, VAL_MAX);
        send(slt_pkg::OP_FIND, VAL_MIN);
        send(slt_pkg::OP_FIND, 7);
        send(slt_pkg::OP_DELETE, 0);
        send(slt_pkg::OP_DELETE, 0);
        send(slt_pkg::OP_DELETE, 0);
        send(slt_pkg::OP_DELETE, VAL_MIN);
        send(slt_pkg::OP_DELETE, VAL_MAX);
        send(slt_pkg::OP_INSERT, 32'sh5555_5555);
        send(slt_pkg::OP_INSERT, 32'shAAAA_AAAA);
        send(slt_pkg::OP_CLEAR, 32'shFFFF_FFFF);
        send(slt_pkg::OP_FIND, -1);

        // Fill to capacity and try two inserts into the full table
        for (int i = 0; i < 66; i++)
            send(slt_pkg::OP_INSERT, pick_value());
        send(slt_pkg::OP_FIND, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        send(slt_pkg::OP_DELETE, value_pool[$urandom_range(0, POOL_SIZE - 1)]);

        // Random phases with shifting operation mixes
        while (sent_items < TOTAL_ITEMS) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(40, 120);
            for (int k = 0; k < len && sent_items < TOTAL_ITEMS; k++)
                send(pick_op(mode), pick_value());
        end
        in_valid <= 1'b0;

        // Drain and give the verdict
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** sorted_list_table: PASSED **");
        else
            $display("** sorted_list_table: FAILED **");
        $finish;
    end

    // Receiver: stall patterns that change now and then, plus one long hold-off
    initial begin : receiver
        int mode;
        int left;
        int phase;
        bit held;
        mode      = 0;
        left      = 0;
        phase     = 0;
        held      = 0;
        out_ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (!held && sent_items >= HOLD_OFF_AT) begin
                held = 1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(30, 150);
            end
            left--;
            phase++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (phase % 5 != 0);
            endcase
            @(negedge clk);
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** sorted_list_table: FAILED **");
                $finish;
            end
        end
    end

endmodule
